/* sv/tbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tbt_pkg;

    // log table size, ln(1 + i/N) in Q30 for i = 0..N
    localparam int LOG_TABLE_ENTRIES_DEF = 256;

    // width of a natural log in Q24 of a 32-bit integer
    localparam int LN_W = 29;

    // ln(2) in Q30
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // configuration register indexes
    localparam logic [2:0] CFG_SERIES  = 3'd0;
    localparam logic [2:0] CFG_NOMINAL = 3'd1;
    localparam logic [2:0] CFG_TEMP    = 3'd2;
    localparam logic [2:0] CFG_BETA    = 3'd3;
    localparam logic [2:0] CFG_REF     = 3'd4;

    // configuration reset values
    localparam logic [19:0] SERIES_RST  = 20'd10000;
    localparam logic [19:0] NOMINAL_RST = 20'd10000;
    localparam logic [8:0]  TEMP_RST    = 9'd25;
    localparam logic [13:0] BETA_RST    = 14'd3977;
    localparam logic [11:0] REF_RST     = 12'd1800;

    // 0 C in centikelvin
    localparam logic [15:0] CENTI_KELVIN = 16'd27315;

    // flags that travel with a word down the pipeline
    typedef struct packed {
        logic inv;   // voltage at or above reference
        logic zero;  // zero resistance, zero R0 or zero beta
        logic mz;    // denominator is zero
        logic neg;   // quotient is negative
        logic ovf;   // quotient magnitude beyond 17 bits
    } tbt_flags_t;

endpackage

`default_nettype wire

/* sv/tbt_ln.sv */
`timescale 1ns / 1ps
`default_nettype none

// natural log in Q24 of a 32-bit integer, five register stages
module tbt_ln
    import tbt_pkg::*;
#(
    parameter int ENTRIES = LOG_TABLE_ENTRIES_DEF
)
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [31:0]     x,
    output logic      [LN_W-1:0] y
);

    localparam int LOG2 = $clog2(ENTRIES);

    typedef logic [29:0] tab_t [0:ENTRIES];

    // unsigned shift-and-subtract quotient, evaluated while the table is built
    function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int s = 63; s >= 0; s--)
        begin
            r = (r << 1) | ((a >> s) & 64'd1);
            if (r >= b)
            begin
                r = r - b;
                q = q | (64'd1 << s);
            end
        end
        return q;
    endfunction

    // ln(1 + i/N) = 2*atanh(i/(2N+i)), series summed in Q31
    function automatic tab_t build_tab();
        tab_t t;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned sum;
        for (int i = 0; i <= ENTRIES; i++)
        begin
            z = udiv(64'(i) << 31, 64'(2 * ENTRIES + i));
            z2 = (z * z) >> 31;
            term = z;
            sum = 0;
            for (int j = 0; j < 24; j++)
            begin
                sum += udiv(term, 64'(2 * j + 1));
                term = (term * z2) >> 31;
            end
            t[i] = 30'(sum);
        end
        return t;
    endfunction

    localparam tab_t LOG_TAB = build_tab();

    logic [31:0]    x1_reg;
    logic [4:0]     k1_reg;
    logic [31:0]    f2_reg;
    logic [29:0]    lo3_reg;
    logic [29:0]    diff3_reg;
    logic [31:0]    r3_reg;
    logic [34:0]    kln3_reg;
    logic [35:0]    base4_reg;
    logic [29:0]    frac4_reg;
    logic [LN_W-1:0] y5_reg;

    logic [4:0]      k_next;
    logic [31:0]     f_next;
    logic [63:0]     f_wide;
    logic [LOG2-1:0] idx;
    logic [LOG2:0]   idx_hi;
    logic [29:0]     tab_lo;
    logic [29:0]     tab_hi;
    logic [61:0]     prod;
    logic [35:0]     y_sum;

    // leading one position
    always_comb
    begin
        k_next = '0;
        for (int i = 1; i < 32; i++)
        begin
            if (x1_reg[i])
            begin
                k_next = 5'(i);
            end
        end
    end

    // mantissa fraction with the leading one dropped
    assign f_wide = {32'b0, x1_reg} << (6'd32 - {1'b0, k_next});
    assign f_next = f_wide[31:0];

    // table cell and interpolation fraction
    assign idx    = f2_reg[31 -: LOG2];
    assign idx_hi = {1'b0, idx} + {{LOG2{1'b0}}, 1'b1};
    assign tab_lo = LOG_TAB[idx];
    assign tab_hi = LOG_TAB[idx_hi];

    assign prod  = 62'(diff3_reg) * 62'(r3_reg);
    assign y_sum = base4_reg + 36'(frac4_reg) + 36'd32;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= x;
            k1_reg    <= k_next;
            f2_reg    <= f_next;
            lo3_reg   <= tab_lo;
            diff3_reg <= tab_hi - tab_lo;
            r3_reg    <= {f2_reg[31-LOG2:0], {LOG2{1'b0}}};
            kln3_reg  <= 35'(k1_reg) * 35'(LN2_Q30);
            base4_reg <= 36'(kln3_reg) + 36'(lo3_reg);
            frac4_reg <= prod[61:32];
            y5_reg    <= y_sum[LN_W+5:6];
        end
    end

    assign y = y5_reg;

endmodule

`default_nettype wire

/* sv/thermistor_beta_temperature.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          content
// s_        in   s_tvalid/s_tready  tdata: voltage_mv
// m_        out  m_tvalid/m_tready  tdata: temperature_centi, tuser: valid_res, saturated
// cfg_      in   cfg_write          cfg_index selects, cfg_data carries the value
//
// one word enters per cycle while the output is not held; each word passes in turn
// through entry and resistance division, log, beta arithmetic, quotient and output
// the whole pipeline holds while a result waits at the output; nothing is lost
// reset clears the valid bits and loads the default configuration
// configuration settles after a write once derived constants and the nominal log follow

module thermistor_beta_temperature
    import tbt_pkg::*;
#(
    parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // voltage_mv[11:0], zeros
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // temperature_centi[15:0]
    output logic [1:0]       m_tuser    // valid_res, saturated
);

    localparam int DIV_N = 32;
    localparam int QB    = 17;
    localparam int LN_N  = 5;

    logic en;

    // configuration registers
    logic [19:0] series_reg;
    logic [19:0] nominal_reg;
    logic [8:0]  temp_reg;
    logic [13:0] beta_reg;
    logic [11:0] ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg  <= SERIES_RST;
            nominal_reg <= NOMINAL_RST;
            temp_reg    <= TEMP_RST;
            beta_reg    <= BETA_RST;
            ref_reg     <= REF_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SERIES:  series_reg  <= cfg_data;
                CFG_NOMINAL: nominal_reg <= cfg_data;
                CFG_TEMP:    temp_reg    <= cfg_data[8:0];
                CFG_BETA:    beta_reg    <= cfg_data[13:0];
                CFG_REF:     ref_reg     <= cfg_data[11:0];
                default:     ;
            endcase
        end
    end

    // constants derived from configuration
    logic [15:0] d_cfg_reg;
    logic [20:0] b100_cfg_reg;
    logic [36:0] n_cfg_reg;
    logic [16:0] d_calc;

    assign d_calc = 17'($signed(temp_reg) * 17'sd100) + {1'b0, CENTI_KELVIN};

    always_ff @(posedge clk)
    begin
        d_cfg_reg    <= d_calc[15:0];
        b100_cfg_reg <= 21'(beta_reg) * 21'd100;
        n_cfg_reg    <= 37'(b100_cfg_reg) * 37'(d_cfg_reg);
    end

    // log of the nominal resistance, free running
    logic [LN_W-1:0] ln_r0;

    tbt_ln #(.ENTRIES(LOG_TABLE_ENTRIES)) u_ln_r0
    (
        .clk (clk),
        .en  (1'b1),
        .x   ({12'b0, nominal_reg}),
        .y   (ln_r0)
    );

    // valid bits
    logic [DIV_N:0] dv_v_reg;
    logic [LN_N:1]  lf_v_reg;
    logic [6:1]     mv_reg;
    logic [QB:0]    qv_reg;

    // entry stage and resistance division
    logic [31:0] d_rem_reg [0:DIV_N];
    logic [31:0] d_q_reg   [0:DIV_N];
    logic [11:0] d_dv_reg  [0:DIV_N];
    logic        d_inv_reg [0:DIV_N];

    logic [11:0] volt;
    assign volt = s_tdata[11:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_rem_reg[0] <= 32'(volt) * 32'(series_reg);
            d_q_reg[0]   <= '0;
            d_dv_reg[0]  <= ref_reg - volt;
            d_inv_reg[0] <= volt >= ref_reg;
        end
    end

    for (genvar j = 1; j <= DIV_N; j++)
    begin : g_div
        localparam int B = DIV_N - j;
        logic [43:0] sh;
        logic        ge;
        assign sh = {32'b0, d_dv_reg[j-1]} << B;
        assign ge = {12'b0, d_rem_reg[j-1]} >= sh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_rem_reg[j] <= ge ? d_rem_reg[j-1] - sh[31:0] : d_rem_reg[j-1];
                d_q_reg[j]   <= d_q_reg[j-1] | (32'(ge) << B);
                d_dv_reg[j]  <= d_dv_reg[j-1];
                d_inv_reg[j] <= d_inv_reg[j-1];
            end
        end
    end

    // log of the resistance, flags ride alongside
    logic [LN_W-1:0] ln_r;
    tbt_flags_t      lf_reg [1:LN_N];
    tbt_flags_t      lf_in;

    tbt_ln #(.ENTRIES(LOG_TABLE_ENTRIES)) u_ln_r
    (
        .clk (clk),
        .en  (en),
        .x   (d_q_reg[DIV_N]),
        .y   (ln_r)
    );

    always_comb
    begin
        lf_in      = '0;
        lf_in.inv  = d_inv_reg[DIV_N];
        lf_in.zero = (d_q_reg[DIV_N] == '0) || (nominal_reg == '0) || (beta_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lf_reg[1] <= lf_in;
            for (int i = 2; i <= LN_N; i++)
            begin
                lf_reg[i] <= lf_reg[i-1];
            end
        end
    end

    // beta arithmetic
    logic signed [29:0] m1_l_reg;
    logic signed [46:0] m2_ld_reg;
    logic signed [47:0] m3_m_reg;
    logic signed [47:0] m4_m_reg;
    logic        [38:0] m4_pl_reg;
    logic signed [39:0] m4_ph_reg;
    logic signed [47:0] m5_m_reg;
    logic signed [63:0] m5_num_reg;
    logic        [63:0] m6_na_reg;
    logic        [47:0] m6_ma_reg;
    tbt_flags_t         mf_reg [1:6];
    tbt_flags_t         mf4_in;
    tbt_flags_t         mf6_in;

    logic signed [63:0] num_next;
    logic signed [63:0] tm;

    assign tm       = (64'(m4_ph_reg) <<< 24) + $signed({25'b0, m4_pl_reg});
    assign num_next = $signed({3'b0, n_cfg_reg, 24'b0}) - tm;

    // zero denominator and result sign join the flags
    always_comb
    begin
        mf4_in    = mf_reg[3];
        mf4_in.mz = (m3_m_reg == '0);
    end

    always_comb
    begin
        mf6_in     = mf_reg[5];
        mf6_in.neg = m5_num_reg[63] ^ m5_m_reg[47];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // difference of logs
            m1_l_reg  <= $signed({1'b0, ln_r}) - $signed({1'b0, ln_r0});
            mf_reg[1] <= lf_reg[LN_N];
            // scaled by nominal centikelvin
            m2_ld_reg <= m1_l_reg * $signed({1'b0, d_cfg_reg});
            mf_reg[2] <= mf_reg[1];
            // denominator
            m3_m_reg  <= 48'(m2_ld_reg) + $signed({3'b0, b100_cfg_reg, 24'b0});
            mf_reg[3] <= mf_reg[2];
            // partial products of 27315 * M
            m4_m_reg  <= m3_m_reg;
            m4_pl_reg <= 39'(CENTI_KELVIN) * 39'(m3_m_reg[23:0]);
            m4_ph_reg <= $signed({1'b0, CENTI_KELVIN}) * 40'($signed(m3_m_reg[47:24]));
            mf_reg[4] <= mf4_in;
            // numerator
            m5_m_reg   <= m4_m_reg;
            m5_num_reg <= num_next;
            mf_reg[5]  <= mf_reg[4];
            // magnitudes and sign
            m6_na_reg <= m5_num_reg[63] ? 64'(-m5_num_reg) : 64'(m5_num_reg);
            m6_ma_reg <= m5_m_reg[47] ? 48'(-m5_m_reg) : 48'(m5_m_reg);
            mf_reg[6] <= mf6_in;
        end
    end

    // quotient: overflow check, then one bit a stage
    logic [63:0] q_rem_reg [0:QB];
    logic [16:0] q_q_reg   [0:QB];
    logic [47:0] q_ma_reg  [0:QB];
    tbt_flags_t  qf_reg    [0:QB];
    tbt_flags_t  qf_in;

    always_comb
    begin
        qf_in     = mf_reg[6];
        qf_in.ovf = {1'b0, m6_na_reg} >= {m6_ma_reg, 17'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_rem_reg[0] <= m6_na_reg;
            q_q_reg[0]   <= '0;
            q_ma_reg[0]  <= m6_ma_reg;
            qf_reg[0]    <= qf_in;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_quo
        localparam int B = QB - j;
        logic [64:0] sh;
        logic        ge;
        assign sh = {17'b0, q_ma_reg[j-1]} << B;
        assign ge = {1'b0, q_rem_reg[j-1]} >= sh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_rem_reg[j] <= ge ? q_rem_reg[j-1] - sh[63:0] : q_rem_reg[j-1];
                q_q_reg[j]   <= q_q_reg[j-1] | (17'(ge) << B);
                q_ma_reg[j]  <= q_ma_reg[j-1];
                qf_reg[j]    <= qf_reg[j-1];
            end
        end
    end

    // result selection and saturation
    logic [15:0] temp_next;
    logic        vres_next;
    logic        sat_next;
    tbt_flags_t  fl;
    logic [16:0] qm;

    assign fl = qf_reg[QB];
    assign qm = q_q_reg[QB];

    always_comb
    begin
        temp_next = '0;
        vres_next = 1'b1;
        sat_next  = 1'b0;
        priority if (fl.inv)
        begin
            vres_next = 1'b0;
        end
        else if (fl.zero)
        begin
            temp_next = 16'(-$signed({1'b0, CENTI_KELVIN}));
        end
        else if (fl.mz)
        begin
            temp_next = 16'h7fff;
            sat_next  = 1'b1;
        end
        else if (fl.ovf)
        begin
            temp_next = fl.neg ? 16'h8000 : 16'h7fff;
            sat_next  = 1'b1;
        end
        else if (fl.neg)
        begin
            if (qm > 17'd32768)
            begin
                temp_next = 16'h8000;
                sat_next  = 1'b1;
            end
            else
            begin
                temp_next = 16'(-qm);
            end
        end
        else
        begin
            if (qm > 17'd32767)
            begin
                temp_next = 16'h7fff;
                sat_next  = 1'b1;
            end
            else
            begin
                temp_next = qm[15:0];
            end
        end
    end

    // output register
    logic        out_v_reg;
    logic [15:0] out_temp_reg;
    logic        out_vres_reg;
    logic        out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_temp_reg <= temp_next;
            out_vres_reg <= vres_next;
            out_sat_reg  <= sat_next;
        end
    end

    // valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg  <= '0;
            lf_v_reg  <= '0;
            mv_reg    <= '0;
            qv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg  <= {dv_v_reg[DIV_N-1:0], s_tvalid};
            lf_v_reg  <= {lf_v_reg[LN_N-1:1], dv_v_reg[DIV_N]};
            mv_reg    <= {mv_reg[5:1], lf_v_reg[LN_N]};
            qv_reg    <= {qv_reg[QB-1:0], mv_reg[6]};
            out_v_reg <= qv_reg[QB];
        end
    end

    // hold the data pipeline while the output word waits
    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_temp_reg;
    assign m_tuser  = {out_sat_reg, out_vres_reg};

endmodule

`default_nettype wire
